// ===== rtl/core/sha1_hash_engine_unit_macros.svh =====
// assertion macros for the sha-1 hash engine
// used by sha1_hash_engine_unit.sv, expects clk and rst_n in scope
`ifndef SHA1_HASH_ENGINE_UNIT_MACROS_SVH
`define SHA1_HASH_ENGINE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SHA1HE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1he same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SHA1HE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1he next-cycle check failed");

`endif

// ===== rtl/core/sha1he_pkg.sv =====
// shared types, constants and round functions of the sha-1 hash engine
// no dependencies; used by sha1he_sched, sha1he_round and the top level
`default_nettype none

package sha1he_pkg;

  localparam int WORD_W   = 32;
  localparam int BLK_WORDS = 16;
  localparam int ROUNDS   = 80;
  localparam int RND_W    = 7;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 61;
  localparam int DIG_WORDS = 5;
  localparam int IDX_W    = 3;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
  localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
  localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

  localparam logic [7:0]       PAD_BYTE  = 8'h80;
  localparam logic [POS_W-1:0] LEN_POS   = 6'd56;
  localparam logic [POS_W-1:0] LAST_POS  = 6'd63;
  localparam logic [RND_W-1:0] LAST_RND  = 7'd79;
  localparam logic [IDX_W-1:0] LAST_IDX  = 3'd4;

  typedef logic [WORD_W-1:0] word_t;

  // message schedule commands
  typedef struct packed {
    logic put;   // shift one byte into the block
    logic step;  // advance the schedule window by one round
  } sched_op_t;

  // round unit commands
  typedef struct packed {
    logic init;  // chaining words back to initial values
    logic load;  // working variables from chaining words
    logic round; // one compression round
    logic fin;   // add working variables into chaining words
  } round_op_t;

  function automatic word_t k_const(input logic [RND_W-1:0] t);
    word_t k;
    if (t < 7'd20)      k = K0;
    else if (t < 7'd40) k = K1;
    else if (t < 7'd60) k = K2;
    else                k = K3;
    return k;
  endfunction

  function automatic word_t f_func(input logic [RND_W-1:0] t,
                                   input word_t b, input word_t c, input word_t d);
    word_t f;
    if (t < 7'd20)      f = (b & c) | (~b & d);
    else if (t < 7'd40) f = b ^ c ^ d;
    else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha1he_sched.sv =====
// block buffer and message schedule window of the sha-1 hash engine
// depends on sha1he_pkg
`default_nettype none

module sha1he_sched (
  input  wire                  clk,
  input  wire sha1he_pkg::sched_op_t op,
  input  wire  [7:0]           byte_in,
  output sha1he_pkg::word_t    w_cur
);

  sha1he_pkg::word_t win_r [sha1he_pkg::BLK_WORDS];
  sha1he_pkg::word_t w_xor;
  sha1he_pkg::word_t w_new;

  // next schedule word w[t+16] from the window w[t..t+15]
  assign w_xor = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {w_xor[30:0], w_xor[31]};
  assign w_cur = win_r[0];

  always_ff @(posedge clk) begin
    if (op.put) begin
      // whole block shifts left one byte, big-endian packing
      for (int i = 0; i < sha1he_pkg::BLK_WORDS - 1; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[sha1he_pkg::BLK_WORDS-1] <= {win_r[sha1he_pkg::BLK_WORDS-1][23:0], byte_in};
    end else if (op.step) begin
      for (int i = 0; i < sha1he_pkg::BLK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sha1he_pkg::BLK_WORDS-1] <= w_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1he_round.sv =====
// shared round unit and chaining words of the sha-1 hash engine
// depends on sha1he_pkg
`default_nettype none

module sha1he_round (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire sha1he_pkg::round_op_t         op,
  input  wire  [sha1he_pkg::RND_W-1:0]       rnd,
  input  wire sha1he_pkg::word_t             w_cur,
  input  wire  [sha1he_pkg::IDX_W-1:0]       sel,
  output sha1he_pkg::word_t                  h_word
);

  sha1he_pkg::word_t h0_r, h1_r, h2_r, h3_r, h4_r;
  sha1he_pkg::word_t a_r, b_r, c_r, d_r, e_r;
  sha1he_pkg::word_t tmp;

  assign tmp = {a_r[26:0], a_r[31:27]} + sha1he_pkg::f_func(rnd, b_r, c_r, d_r)
             + e_r + sha1he_pkg::k_const(rnd) + w_cur;

  always_ff @(posedge clk) begin
    if (!rst_n || op.init) begin
      h0_r <= sha1he_pkg::IV0;
      h1_r <= sha1he_pkg::IV1;
      h2_r <= sha1he_pkg::IV2;
      h3_r <= sha1he_pkg::IV3;
      h4_r <= sha1he_pkg::IV4;
    end else if (op.fin) begin
      h0_r <= h0_r + a_r;
      h1_r <= h1_r + b_r;
      h2_r <= h2_r + c_r;
      h3_r <= h3_r + d_r;
      h4_r <= h4_r + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (op.load) begin
      a_r <= h0_r;
      b_r <= h1_r;
      c_r <= h2_r;
      d_r <= h3_r;
      e_r <= h4_r;
    end else if (op.round) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_comb begin
    case (sel)
      3'd0:    h_word = h0_r;
      3'd1:    h_word = h1_r;
      3'd2:    h_word = h2_r;
      3'd3:    h_word = h3_r;
      3'd4:    h_word = h4_r;
      default: h_word = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_hash_engine_unit.sv =====
// sha-1 hash engine top level: sequencer, byte and pad control, digest output
// depends on sha1he_pkg, sha1he_sched, sha1he_round and the assertion macro header
//
// takes a message one byte per word on the in_ channel, in_final_byte on the
// last byte, and returns the 160-bit digest as five 32-bit words on the out_
// channel, most significant first (word_number 0..4, last_word on word 4).
// a byte that does not complete a 64-byte block is only shifted in. a byte that
// completes a block also starts the compression: 80 rounds on the shared round
// unit, one per cycle, then the chaining add, with in_stall high meanwhile. after
// the final byte the engine feeds the 0x80 pad, the zero fill and the 8 length
// bytes through the same byte path at one byte per cycle between compressions,
// compressing once or twice more, then shows the 5 digest words, one per cycle
// unless out_stall holds them. no new message byte is taken until the last
// digest word is gone; the engine then returns to the initial chaining values
// and a zero length.
`default_nettype none

`include "sha1_hash_engine_unit_macros.svh"

module sha1_hash_engine_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_final_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0; // waiting for a message byte
  localparam logic [2:0] S_COMP = 3'd1; // compression rounds
  localparam logic [2:0] S_FIN  = 3'd2; // chaining add
  localparam logic [2:0] S_PAD  = 3'd3; // pad and length bytes
  localparam logic [2:0] S_OUT  = 3'd4; // digest words out

  logic [2:0]                       state_r, state_nxt;
  logic [sha1he_pkg::POS_W-1:0]     pos_r, pos_nxt;      // byte position in block
  logic [sha1he_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;      // message byte count
  logic [sha1he_pkg::RND_W-1:0]     rnd_r, rnd_nxt;      // round index
  logic [sha1he_pkg::IDX_W-1:0]     idx_r, idx_nxt;      // digest word index
  logic                             pad_r, pad_nxt;      // padding in progress
  logic                             first_r, first_nxt;  // next pad byte is 0x80
  logic                             lenph_r, lenph_nxt;  // length bytes started
  logic                             done_r, done_nxt;    // last block compressed next

  sha1he_pkg::sched_op_t            s_op;
  sha1he_pkg::round_op_t            r_op;
  logic [7:0]                       put_byte;
  logic [7:0]                       pad_byte;
  logic [63:0]                      len_bits;
  logic                             in_acc;
  logic                             len_now;
  sha1he_pkg::word_t                w_cur;
  sha1he_pkg::word_t                h_word;

  assign in_acc   = in_valid && !in_stall;
  assign len_bits = {cnt_r, 3'b000};
  // length phase begins at block position 56 once the 0x80 is placed
  assign len_now  = !first_r && (lenph_r || (pos_r == sha1he_pkg::LEN_POS));

  // length bytes go out most significant first, position 56 picks the top byte
  always_comb begin
    if (first_r) begin
      pad_byte = sha1he_pkg::PAD_BYTE;
    end else if (len_now) begin
      pad_byte = len_bits[(7 - pos_r[2:0]) * 8 +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    pad_nxt   = pad_r;
    first_nxt = first_r;
    lenph_nxt = lenph_r;
    done_nxt  = done_r;
    s_op      = '0;
    r_op      = '0;
    put_byte  = in_data_byte;
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          s_op.put = 1'b1;
          pos_nxt  = pos_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (in_final_byte) begin
            pad_nxt   = 1'b1;
            first_nxt = 1'b1;
          end
          if (pos_r == sha1he_pkg::LAST_POS) begin
            r_op.load = 1'b1;
            rnd_nxt   = '0;
            state_nxt = S_COMP;
          end else if (in_final_byte) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        s_op.put  = 1'b1;
        put_byte  = pad_byte;
        pos_nxt   = pos_r + 1'b1;
        first_nxt = 1'b0;
        if (len_now) begin
          lenph_nxt = 1'b1;
        end
        if (pos_r == sha1he_pkg::LAST_POS) begin
          r_op.load = 1'b1;
          rnd_nxt   = '0;
          state_nxt = S_COMP;
          if (len_now) begin
            done_nxt = 1'b1;
          end
        end
      end
      S_COMP: begin
        r_op.round = 1'b1;
        s_op.step  = 1'b1;
        rnd_nxt    = rnd_r + 1'b1;
        if (rnd_r == sha1he_pkg::LAST_RND) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        r_op.fin = 1'b1;
        if (done_r) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (idx_r == sha1he_pkg::LAST_IDX) begin
            // restart for the next message
            r_op.init = 1'b1;
            cnt_nxt   = '0;
            pad_nxt   = 1'b0;
            lenph_nxt = 1'b0;
            done_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      cnt_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      pad_r   <= 1'b0;
      first_r <= 1'b0;
      lenph_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      pad_r   <= pad_nxt;
      first_r <= first_nxt;
      lenph_r <= lenph_nxt;
      done_r  <= done_nxt;
    end
  end

  sha1he_sched u_sched (
    .clk     (clk),
    .op      (s_op),
    .byte_in (put_byte),
    .w_cur   (w_cur)
  );

  sha1he_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (r_op),
    .rnd    (rnd_r),
    .w_cur  (w_cur),
    .sel    (idx_r),
    .h_word (h_word)
  );

  assign out_digest_word = h_word;
  assign out_word_number = idx_r;
  assign out_last_word   = (idx_r == sha1he_pkg::LAST_IDX);

  // a digest on show keeps the byte side closed
  `SHA1HE_ASSERT_SAME(a_out_blocks_in, out_valid, in_stall)
  // the round index never runs past the last round while compressing
  `SHA1HE_ASSERT_SAME(a_rnd_range, state_r == S_COMP, rnd_r <= sha1he_pkg::LAST_RND)
  // after the last digest word the engine is back at the start of a block
  `SHA1HE_ASSERT_NEXT(a_restart, out_valid && !out_stall && out_last_word,
                      state_r == S_IDLE && pos_r == '0 && cnt_r == '0)
  // a block that fills always starts the rounds
  `SHA1HE_ASSERT_NEXT(a_fill_comp, s_op.put && pos_r == sha1he_pkg::LAST_POS,
                      state_r == S_COMP && rnd_r == '0)

endmodule

`default_nettype wire
